// ===== design/tcf_pkg.sv =====
// Package for the tilt complementary filter: widths, CORDIC table, state and command types.
// No dependencies.
package tcf_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int STEPS_USED = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam int ITER_W = 5;
    localparam int CW = 40;
    localparam int ANG_W = 24;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_WEIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_STEP = 1'b1;

    typedef logic signed [ANG_W-1:0] angle_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_CORDIC,
        ST_BLEND,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic cordic_init;
        logic cordic_iter;
        logic blend;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic cordic_last;
    } stat_t;

    function automatic logic signed [31:0] atan_deg16(input logic [ITER_W-1:0] i);
        case (i)
            5'd0: return 32'sd2949120;
            5'd1: return 32'sd1740967;
            5'd2: return 32'sd919879;
            5'd3: return 32'sd466945;
            5'd4: return 32'sd234379;
            5'd5: return 32'sd117304;
            5'd6: return 32'sd58666;
            5'd7: return 32'sd29335;
            5'd8: return 32'sd14668;
            5'd9: return 32'sd7334;
            5'd10: return 32'sd3667;
            5'd11: return 32'sd1833;
            5'd12: return 32'sd917;
            5'd13: return 32'sd458;
            5'd14: return 32'sd229;
            5'd15: return 32'sd115;
            5'd16: return 32'sd57;
            5'd17: return 32'sd29;
            5'd18: return 32'sd14;
            5'd19: return 32'sd7;
            5'd20: return 32'sd4;
            5'd21: return 32'sd2;
            5'd22: return 32'sd1;
            default: return 32'sd0;
        endcase
    endfunction

    function automatic angle_t sat24(input logic signed [47:0] v);
        if (v > 48'sd8388607) return 24'sd8388607;
        if (v < -48'sd8388608) return -24'sd8388608;
        return v[ANG_W-1:0];
    endfunction
endpackage

// ===== design/tcf_if.sv =====
// Valid/ready channel interfaces for input samples and output angles.
// No dependencies.
interface tcf_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    modport source (output valid, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z,
                    input ready);
    modport sink (input valid, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z,
                  output ready);
endinterface

interface tcf_out_if;
    logic valid;
    logic ready;
    logic signed [23:0] roll_angle;
    logic signed [23:0] pitch_angle;
    logic signed [23:0] yaw_angle;
    modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
    modport sink (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

// ===== design/tcf_ctrl.sv =====
// Sequencer for the filter: step, shared CORDIC iterations, blend, output beat.
// Depends on tcf_pkg.
module tcf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  tcf_pkg::stat_t stat,
    output tcf_pkg::cmd_t  cmd
);
    import tcf_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_STEP;
            ST_STEP:   state_next = ST_CORDIC;
            ST_CORDIC: if (stat.cordic_last) state_next = ST_BLEND;
            ST_BLEND:  state_next = ST_OUT;
            ST_OUT:    if (out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_STEP:
            begin
                cmd.step = 1'b1;
                cmd.cordic_init = 1'b1;
            end
            ST_CORDIC: cmd.cordic_iter = 1'b1;
            ST_BLEND:
            begin
                cmd.blend = 1'b1;
                cmd.commit = 1'b1;
            end
            ST_OUT: out_valid = 1'b1;
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("accept while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_load_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.step) else $error("load not followed by step");
`endif
endmodule

// ===== design/tcf_datapath.sv =====
// Datapath: rate step multiplier, two CORDIC lanes sharing one iteration counter, blend.
// Depends on tcf_pkg.
module tcf_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  tcf_pkg::cmd_t       cmd,
    output tcf_pkg::stat_t      stat,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic signed [15:0]  rate_x,
    input  logic signed [15:0]  rate_y,
    input  logic signed [15:0]  rate_z,
    input  logic signed [15:0]  accel_x,
    input  logic signed [15:0]  accel_y,
    input  logic signed [15:0]  accel_z,
    output tcf_pkg::angle_t     roll_angle,
    output tcf_pkg::angle_t     pitch_angle,
    output tcf_pkg::angle_t     yaw_angle
);
    import tcf_pkg::*;

    logic [15:0] weight_reg, scale_reg;
    angle_t roll_reg, pitch_reg, yaw_reg;
    angle_t roll_g_reg, pitch_g_reg;
    logic signed [15:0] rx_reg, ry_reg, rz_reg, ax_reg, ay_reg, az_reg;
    logic signed [CW-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic signed [CW-1:0] a0_reg, a1_reg;
    logic zero0_reg, zero1_reg;
    logic [ITER_W-1:0] iter_reg;

    function automatic logic signed [17:0] step_of(input logic signed [15:0] r);
        logic signed [33:0] p;
        p = 34'(r) * $signed({1'b0, scale_reg}) + 34'sd32768;
        return 18'(p >>> 16);
    endfunction

    function automatic angle_t blend_of(input angle_t est, input logic signed [CW-1:0] acc);
        logic signed [CW-1:0] aa;
        logic signed [47:0] s;
        aa = (acc + 40'sd512) >>> 10;
        s = 48'(est) * $signed({1'b0, weight_reg})
            + 48'(aa) * $signed({1'b0, 17'd65536 - 17'(weight_reg)}) + 48'sd32768;
        return sat24(s >>> 16);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= 16'd62259;
            scale_reg  <= 16'd655;
            roll_reg   <= '0;
            pitch_reg  <= '0;
            yaw_reg    <= '0;
            iter_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_GYRO_WEIGHT: weight_reg <= cfg_data;
                    REG_RATE_STEP:   scale_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.step)
                yaw_reg <= sat24(48'(yaw_reg) + 48'(step_of(rz_reg)));
            if (cmd.commit)
            begin
                roll_reg  <= blend_of(roll_g_reg, a0_reg);
                pitch_reg <= blend_of(pitch_g_reg, a1_reg);
            end
            if (cmd.cordic_init)
                iter_reg <= '0;
            else if (cmd.cordic_iter)
                iter_reg <= iter_reg + 1'b1;
        end
    end

    assign stat.cordic_last = (iter_reg == ITER_W'(STEPS_USED - 1));

    always_ff @(posedge clk)
    begin
        logic signed [CW-1:0] xs0, ys0, xs1, ys1, th;
        if (cmd.load)
        begin
            rx_reg <= rate_x; ry_reg <= rate_y; rz_reg <= rate_z;
            ax_reg <= accel_x; ay_reg <= accel_y; az_reg <= accel_z;
        end
        if (cmd.step)
        begin
            roll_g_reg  <= sat24(48'(roll_reg) + 48'(step_of(rx_reg)));
            pitch_g_reg <= sat24(48'(pitch_reg) + 48'(step_of(ry_reg)));
        end
        if (cmd.cordic_init)
        begin
            zero0_reg <= (ay_reg == 0) && (az_reg == 0);
            zero1_reg <= (ax_reg == 0) && (az_reg == 0);
            if (az_reg < 0)
            begin
                x0_reg <= -(CW'(az_reg) <<< 16); y0_reg <= -(CW'(ay_reg) <<< 16);
                x1_reg <= -(CW'(az_reg) <<< 16); y1_reg <= -(CW'(ax_reg) <<< 16);
                a0_reg <= (ay_reg >= 0) ? 40'sd11796480 : -40'sd11796480;
                a1_reg <= (ax_reg >= 0) ? 40'sd11796480 : -40'sd11796480;
            end
            else
            begin
                x0_reg <= CW'(az_reg) <<< 16; y0_reg <= CW'(ay_reg) <<< 16;
                x1_reg <= CW'(az_reg) <<< 16; y1_reg <= CW'(ax_reg) <<< 16;
                a0_reg <= '0; a1_reg <= '0;
            end
        end
        else if (cmd.cordic_iter)
        begin
            th = CW'(atan_deg16(iter_reg));
            xs0 = x0_reg >>> iter_reg; ys0 = y0_reg >>> iter_reg;
            xs1 = x1_reg >>> iter_reg; ys1 = y1_reg >>> iter_reg;
            if (y0_reg >= 0)
            begin
                x0_reg <= x0_reg + ys0; y0_reg <= y0_reg - xs0;
                a0_reg <= zero0_reg ? a0_reg : a0_reg + th;
            end
            else
            begin
                x0_reg <= x0_reg - ys0; y0_reg <= y0_reg + xs0;
                a0_reg <= zero0_reg ? a0_reg : a0_reg - th;
            end
            if (y1_reg >= 0)
            begin
                x1_reg <= x1_reg + ys1; y1_reg <= y1_reg - xs1;
                a1_reg <= zero1_reg ? a1_reg : a1_reg + th;
            end
            else
            begin
                x1_reg <= x1_reg - ys1; y1_reg <= y1_reg + xs1;
                a1_reg <= zero1_reg ? a1_reg : a1_reg - th;
            end
        end
        else if (cmd.blend)
        begin
            if (zero0_reg) a0_reg <= '0;
            if (zero1_reg) a1_reg <= '0;
        end
    end

    assign roll_angle  = roll_reg;
    assign pitch_angle = pitch_reg;
    assign yaw_angle   = yaw_reg;

`ifndef SYNTHESIS
    a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cordic_iter |-> iter_reg < ITER_W'(STEPS_USED)) else $error("iteration overrun");
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit && !cmd.step |=> $stable(roll_reg) && $stable(yaw_reg))
        else $error("estimate changed outside update");
    a_init_iter: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cordic_init |=> iter_reg == '0) else $error("counter not cleared");
`endif
endmodule

// ===== design/tilt_complementary_filter.sv =====
// Top level of the tilt complementary filter: controller plus datapath.
// Depends on tcf_pkg, tcf_if, tcf_ctrl, tcf_datapath.
// One sample is taken when idle and its angles are offered after the step state, the
// CORDIC iteration loop that both lanes share and the blend state; the next
// sample is taken the cycle after the result beat. Registers are written via cfg_we.
module tilt_complementary_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    tcf_in_if.sink      in_ch,
    tcf_out_if.source   out_ch
);
    import tcf_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    tcf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .stat(stat), .cmd(cmd)
    );

    tcf_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .rate_x(in_ch.rate_x), .rate_y(in_ch.rate_y), .rate_z(in_ch.rate_z),
        .accel_x(in_ch.accel_x), .accel_y(in_ch.accel_y), .accel_z(in_ch.accel_z),
        .roll_angle(out_ch.roll_angle), .pitch_angle(out_ch.pitch_angle),
        .yaw_angle(out_ch.yaw_angle)
    );
endmodule
